### rtl/core/ptc_pkg.sv
// Shared constants and types of the pressure and temperature compensation core.
`timescale 1ns / 1ps
`default_nettype none

package ptc_pkg;

    // Field widths
    localparam int RAW_W      = 20;
    localparam int TEMP_W     = 15;
    localparam int PRESS_W    = 32;
    localparam int CFG_DATA_W = 64;
    localparam int CFG_IDX_W  = 2;

    // Divider geometry: 64-bit dividend magnitude, 31-bit divisor magnitude
    localparam int DIV_NUM_W  = 64;
    localparam int DIV_DEN_W  = 31;

    typedef logic [CFG_IDX_W-1:0] t_cfg_idx;

    // Register indexes
    localparam t_cfg_idx REG_TEMP_COEFFS = 2'd0;
    localparam t_cfg_idx REG_PRESS_LOW   = 2'd1;
    localparam t_cfg_idx REG_PRESS_HIGH  = 2'd2;
    localparam t_cfg_idx REG_PRESS_NINE  = 2'd3;

    // Temperature limits in 0.01 degC
    localparam logic signed [TEMP_W-1:0] TEMP_MIN = -15'sd4000;
    localparam logic signed [TEMP_W-1:0] TEMP_MAX = 15'sd8500;

    // Fine temperature offset of the pressure path
    localparam logic signed [25:0] T_FINE_OFFSET = 26'sd128000;

    // Sideband that rides along the divider
    typedef struct packed {
        logic signed [TEMP_W-1:0] temp;
        logic                     zero;
        logic                     neg;
    } t_div_side;

endpackage

`default_nettype wire

### rtl/core/ptc_in_if.sv
// Input channel carrying one raw temperature and pressure reading pair.
`timescale 1ns / 1ps
`default_nettype none

interface ptc_in_if;
    logic        valid;
    logic        ready;
    logic [19:0] temp_raw;
    logic [19:0] press_raw;

    modport source (output valid, output temp_raw, output press_raw, input ready);
    modport sink   (input valid, input temp_raw, input press_raw, output ready);
endinterface

`default_nettype wire

### rtl/core/ptc_out_if.sv
// Output channel carrying one compensated temperature and pressure result.
`timescale 1ns / 1ps
`default_nettype none

interface ptc_out_if;
    logic               valid;
    logic               ready;
    logic signed [14:0] temperature_centi;
    logic [31:0]        pressure_q24_8;
    logic               pressure_invalid;

    modport source (output valid, output temperature_centi, output pressure_q24_8,
                    output pressure_invalid, input ready);
    modport sink   (input valid, input temperature_centi, input pressure_q24_8,
                    input pressure_invalid, output ready);
endinterface

`default_nettype wire

### rtl/core/pressure_temperature_compensation_core.sv
// Top level of the pressure and temperature compensation core.
//
// Usage: write the four calibration registers through the config port (index 0
// temperature coefficients, 1 and 2 pressure coefficients, 3 coefficient nine) while
// the core is idle, then stream raw reading pairs on i_in. Each input beat yields
// exactly one result beat on o_out, in order: temperature in 0.01 degC (saturated to
// -4000..8500), pressure in Q24.8 pascal and an invalid flag for a zero denominator.
// Throughput is one beat per cycle while the skid register is empty. There are 80
// register stages: 10 stages of temperature and coefficient arithmetic, 64 stages of
// the one-bit-per-stage pressure divider and 6 stages of second-order correction. The
// first stage loads at the accepting edge, and the result shows on o_out from the
// last stage or from the skid register.
// Reset clears the calibration registers to zero and drops every beat in flight.
// When the receiver stalls, a one-entry skid register takes the last result and the
// pipeline freezes while it is full; nothing is dropped or repeated.
`timescale 1ns / 1ps
`default_nettype none

module pressure_temperature_compensation_core import ptc_pkg::*; (
    input  wire logic                  i_clk,
    input  wire logic                  i_rst_n,
    input  wire logic                  i_cfg_we,
    input  wire t_cfg_idx              i_cfg_idx,
    input  wire logic [CFG_DATA_W-1:0] i_cfg_data,
    ptc_in_if.sink                     i_in,
    ptc_out_if.source                  o_out
);

    // Calibration registers
    logic [47:0] r_temp_coeffs;
    logic [63:0] r_press_low;
    logic [63:0] r_press_high;
    logic [15:0] r_press_nine;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_temp_coeffs <= '0;
            r_press_low   <= '0;
            r_press_high  <= '0;
            r_press_nine  <= '0;
        end else if (i_cfg_we) begin
            case (i_cfg_idx)
                REG_TEMP_COEFFS: r_temp_coeffs <= i_cfg_data[47:0];
                REG_PRESS_LOW:   r_press_low   <= i_cfg_data;
                REG_PRESS_HIGH:  r_press_high  <= i_cfg_data;
                REG_PRESS_NINE:  r_press_nine  <= i_cfg_data[15:0];
                default: ;
            endcase
        end
    end

    // Unpack coefficients
    logic        [15:0] w_t1, w_p1;
    logic signed [15:0] w_t2, w_t3, w_p2, w_p3, w_p4, w_p5, w_p6, w_p7, w_p8, w_p9;

    assign w_t1 = r_temp_coeffs[15:0];
    assign w_t2 = $signed(r_temp_coeffs[31:16]);
    assign w_t3 = $signed(r_temp_coeffs[47:32]);
    assign w_p1 = r_press_low[15:0];
    assign w_p2 = $signed(r_press_low[31:16]);
    assign w_p3 = $signed(r_press_low[47:32]);
    assign w_p4 = $signed(r_press_low[63:48]);
    assign w_p5 = $signed(r_press_high[15:0]);
    assign w_p6 = $signed(r_press_high[31:16]);
    assign w_p7 = $signed(r_press_high[47:32]);
    assign w_p8 = $signed(r_press_high[63:48]);
    assign w_p9 = $signed(r_press_nine);

    // Advance the whole pipeline unless the skid register is holding a beat
    logic r_skid_valid;
    logic w_adv;

    assign w_adv      = !r_skid_valid;
    assign i_in.ready = w_adv;

    // Valid bits of the front and back sections
    logic [9:0] r_fv;
    logic [5:0] r_bv;
    logic       w_div_valid;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_fv <= '0;
            r_bv <= '0;
        end else if (w_adv) begin
            r_fv <= {r_fv[8:0], i_in.valid};
            r_bv <= {r_bv[4:0], w_div_valid};
        end
    end

    // Stage 1: offset raw temperature, first products
    logic signed [18:0] w_tx1;
    logic signed [17:0] w_d;
    logic signed [34:0] r1_v1m;
    logic signed [35:0] r1_dd;
    logic [RAW_W-1:0]   r1_pr;

    assign w_tx1 = $signed({2'b00, i_in.temp_raw[19:3]}) - $signed({2'b00, w_t1, 1'b0});
    assign w_d   = $signed({2'b00, i_in.temp_raw[19:4]}) - $signed({2'b00, w_t1});

    always_ff @(posedge i_clk) begin
        if (w_adv) begin
            r1_v1m <= w_tx1 * w_t2;
            r1_dd  <= w_d * w_d;
            r1_pr  <= i_in.press_raw;
        end
    end

    // Stage 2: scale first term, square term times T3
    logic signed [23:0] r2_v1;
    logic signed [37:0] r2_v2m;
    logic [RAW_W-1:0]   r2_pr;

    always_ff @(posedge i_clk) begin
        if (w_adv) begin
            r2_v1  <= r1_v1m[34:11];
            r2_v2m <= $signed({1'b0, r1_dd[32:12]}) * w_t3;
            r2_pr  <= r1_pr;
        end
    end

    // Stage 3: fine temperature
    logic signed [24:0] r3_tf;
    logic [RAW_W-1:0]   r3_pr;

    always_ff @(posedge i_clk) begin
        if (w_adv) begin
            r3_tf <= 25'(r2_v1) + 25'($signed(r2_v2m[37:14]));
            r3_pr <= r2_pr;
        end
    end

    // Stage 4: saturated temperature and pressure offset
    logic signed [27:0]       w_t5;
    logic signed [19:0]       w_tsh;
    logic signed [TEMP_W-1:0] r4_t;
    logic signed [25:0]       r4_a;
    logic [RAW_W-1:0]         r4_pr;

    assign w_t5  = (28'(r3_tf) <<< 2) + 28'(r3_tf) + 28'sd128;
    assign w_tsh = w_t5[27:8];

    always_ff @(posedge i_clk) begin
        if (w_adv) begin
            if (w_tsh < 20'(TEMP_MIN)) begin
                r4_t <= TEMP_MIN;
            end else if (w_tsh > 20'(TEMP_MAX)) begin
                r4_t <= TEMP_MAX;
            end else begin
                r4_t <= w_tsh[TEMP_W-1:0];
            end
            r4_a  <= 26'(r3_tf) - T_FINE_OFFSET;
            r4_pr <= r3_pr;
        end
    end

    // Stage 5: square of the offset and linear products
    logic signed [51:0]       r5_aa;
    logic signed [41:0]       r5_ap5, r5_ap2;
    logic signed [TEMP_W-1:0] r5_t;
    logic [RAW_W-1:0]         r5_pr;

    always_ff @(posedge i_clk) begin
        if (w_adv) begin
            r5_aa  <= r4_a * r4_a;
            r5_ap5 <= r4_a * w_p5;
            r5_ap2 <= r4_a * w_p2;
            r5_t   <= r4_t;
            r5_pr  <= r4_pr;
        end
    end

    // Stage 6: quadratic products, wrapped to 64 bits
    logic signed [67:0]       w_aap6, w_aap3;
    logic [63:0]              r6_b1, r6_c1;
    logic signed [41:0]       r6_ap5, r6_ap2;
    logic signed [TEMP_W-1:0] r6_t;
    logic [RAW_W-1:0]         r6_pr;

    assign w_aap6 = r5_aa * w_p6;
    assign w_aap3 = r5_aa * w_p3;

    always_ff @(posedge i_clk) begin
        if (w_adv) begin
            r6_b1  <= w_aap6[63:0];
            r6_c1  <= w_aap3[63:0];
            r6_ap5 <= r5_ap5;
            r6_ap2 <= r5_ap2;
            r6_t   <= r5_t;
            r6_pr  <= r5_pr;
        end
    end

    // Stage 7: offset term and sensitivity term
    logic [63:0]              r7_b, r7_c;
    logic signed [TEMP_W-1:0] r7_t;
    logic [RAW_W-1:0]         r7_pr;

    always_ff @(posedge i_clk) begin
        if (w_adv) begin
            r7_b  <= r6_b1 + (64'(r6_ap5) << 17) + (64'(w_p4) << 35);
            r7_c  <= 64'($signed(r6_c1) >>> 8) + (64'(r6_ap2) << 12);
            r7_t  <= r6_t;
            r7_pr <= r6_pr;
        end
    end

    // Stage 8: denominator product and numerator base
    logic [63:0]              w_base;
    logic [79:0]              w_denm;
    logic [20:0]              w_prd;
    logic [63:0]              r8_denm, r8_num;
    logic signed [TEMP_W-1:0] r8_t;

    assign w_base = (64'd1 << 47) + r7_c;
    assign w_denm = w_base * w_p1;
    assign w_prd  = 21'd1048576 - {1'b0, r7_pr};

    always_ff @(posedge i_clk) begin
        if (w_adv) begin
            r8_denm <= w_denm[63:0];
            r8_num  <= (64'(w_prd) << 31) - r7_b;
            r8_t    <= r7_t;
        end
    end

    // Stage 9: scaled denominator, numerator times 3125
    logic [75:0]              w_n3125;
    logic signed [30:0]       r9_den;
    logic [63:0]              r9_num;
    logic signed [TEMP_W-1:0] r9_t;

    assign w_n3125 = r8_num * 12'd3125;

    always_ff @(posedge i_clk) begin
        if (w_adv) begin
            r9_den <= r8_denm[63:33];
            r9_num <= w_n3125[63:0];
            r9_t   <= r8_t;
        end
    end

    // Stage 10: magnitudes and quotient sign for the divider
    logic [DIV_NUM_W-1:0] r10_mn;
    logic [DIV_DEN_W-1:0] r10_md;
    t_div_side            r10_side;

    always_ff @(posedge i_clk) begin
        if (w_adv) begin
            r10_mn        <= r9_num[63] ? (64'd0 - r9_num) : r9_num;
            r10_md        <= r9_den[30] ? DIV_DEN_W'(31'd0 - r9_den) : r9_den;
            r10_side.temp <= r9_t;
            r10_side.zero <= (r9_den == '0);
            r10_side.neg  <= r9_num[63] ^ r9_den[30];
        end
    end

    // Divider
    logic [DIV_NUM_W-1:0] w_quot;
    t_div_side            w_div_side;

    ptc_div u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (w_adv),
        .i_valid (r_fv[9]),
        .i_num   (r10_mn),
        .i_den   (r10_md),
        .i_side  (r10_side),
        .o_valid (w_div_valid),
        .o_quot  (w_quot),
        .o_side  (w_div_side)
    );

    // Stage A: signed quotient
    logic [63:0]              r_a_p;
    logic signed [TEMP_W-1:0] r_a_t;
    logic                     r_a_zero;

    always_ff @(posedge i_clk) begin
        if (w_adv) begin
            r_a_p    <= w_div_side.neg ? (64'd0 - w_quot) : w_quot;
            r_a_t    <= w_div_side.temp;
            r_a_zero <= w_div_side.zero;
        end
    end

    // Stage B: P9 times quotient over 2^13, P8 times quotient
    logic signed [50:0]       w_q13;
    logic signed [66:0]       w_p9q;
    logic signed [79:0]       w_p8p;
    logic [63:0]              r_b_p9q, r_b_p8p, r_b_p;
    logic signed [50:0]       r_b_q13;
    logic signed [TEMP_W-1:0] r_b_t;
    logic                     r_b_zero;

    assign w_q13 = r_a_p[63:13];
    assign w_p9q = w_p9 * w_q13;
    assign w_p8p = w_p8 * $signed(r_a_p);

    always_ff @(posedge i_clk) begin
        if (w_adv) begin
            r_b_p9q  <= w_p9q[63:0];
            r_b_p8p  <= w_p8p[63:0];
            r_b_q13  <= w_q13;
            r_b_p    <= r_a_p;
            r_b_t    <= r_a_t;
            r_b_zero <= r_a_zero;
        end
    end

    // Stage C: partial products of the wrapped 64-bit square term
    logic [63:0]              w_y, w_lh, w_hl;
    logic [63:0]              r_c_ll, r_c_v2, r_c_p;
    logic [31:0]              r_c_lh, r_c_hl;
    logic signed [TEMP_W-1:0] r_c_t;
    logic                     r_c_zero;

    assign w_y  = 64'(r_b_q13);
    assign w_lh = r_b_p9q[31:0] * w_y[63:32];
    assign w_hl = r_b_p9q[63:32] * w_y[31:0];

    always_ff @(posedge i_clk) begin
        if (w_adv) begin
            r_c_ll   <= r_b_p9q[31:0] * w_y[31:0];
            r_c_lh   <= w_lh[31:0];
            r_c_hl   <= w_hl[31:0];
            r_c_v2   <= 64'($signed(r_b_p8p) >>> 19);
            r_c_p    <= r_b_p;
            r_c_t    <= r_b_t;
            r_c_zero <= r_b_zero;
        end
    end

    // Stage D: assemble the square term and scale it
    logic [63:0]              w_v1m;
    logic [63:0]              r_d_v1, r_d_v2, r_d_p;
    logic signed [TEMP_W-1:0] r_d_t;
    logic                     r_d_zero;

    assign w_v1m = r_c_ll + {32'(r_c_lh + r_c_hl), 32'd0};

    always_ff @(posedge i_clk) begin
        if (w_adv) begin
            r_d_v1   <= 64'($signed(w_v1m) >>> 25);
            r_d_v2   <= r_c_v2;
            r_d_p    <= r_c_p;
            r_d_t    <= r_c_t;
            r_d_zero <= r_c_zero;
        end
    end

    // Stage E: corrected sum
    logic [63:0]              r_e_s;
    logic signed [TEMP_W-1:0] r_e_t;
    logic                     r_e_zero;

    always_ff @(posedge i_clk) begin
        if (w_adv) begin
            r_e_s    <= r_d_p + r_d_v1 + r_d_v2;
            r_e_t    <= r_d_t;
            r_e_zero <= r_d_zero;
        end
    end

    // Stage F: final pressure, saturate, force zero on invalid
    logic [63:0]              w_f;
    logic [PRESS_W-1:0]       r_f_press;
    logic                     r_f_inv;
    logic signed [TEMP_W-1:0] r_f_t;

    assign w_f = 64'($signed(r_e_s) >>> 8) + (64'(w_p7) << 4);

    always_ff @(posedge i_clk) begin
        if (w_adv) begin
            if (r_e_zero || w_f[63]) begin
                r_f_press <= '0;
            end else if (|w_f[63:PRESS_W]) begin
                r_f_press <= '1;
            end else begin
                r_f_press <= w_f[PRESS_W-1:0];
            end
            r_f_inv <= r_e_zero;
            r_f_t   <= r_e_t;
        end
    end

    // Skid register: hold the last beat while the receiver stalls
    logic [PRESS_W-1:0]       r_skid_press;
    logic                     r_skid_inv;
    logic signed [TEMP_W-1:0] r_skid_t;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_skid_valid <= 1'b0;
        end else if (r_skid_valid) begin
            if (o_out.ready) begin
                r_skid_valid <= 1'b0;
            end
        end else if (r_bv[5] && !o_out.ready) begin
            r_skid_valid <= 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!r_skid_valid) begin
            r_skid_press <= r_f_press;
            r_skid_inv   <= r_f_inv;
            r_skid_t     <= r_f_t;
        end
    end

    // Present the skid beat first, else the last stage
    assign o_out.valid             = r_skid_valid || r_bv[5];
    assign o_out.pressure_q24_8    = r_skid_valid ? r_skid_press : r_f_press;
    assign o_out.pressure_invalid  = r_skid_valid ? r_skid_inv : r_f_inv;
    assign o_out.temperature_centi = r_skid_valid ? r_skid_t : r_f_t;

endmodule

`default_nettype wire

### rtl/core/ptc_div.sv
// Pipelined restoring divider, one quotient bit per stage, with a sideband.
`timescale 1ns / 1ps
`default_nettype none

module ptc_div import ptc_pkg::*; (
    input  wire logic                 i_clk,
    input  wire logic                 i_rst_n,
    input  wire logic                 i_en,
    input  wire logic                 i_valid,
    input  wire logic [DIV_NUM_W-1:0] i_num,
    input  wire logic [DIV_DEN_W-1:0] i_den,
    input  wire t_div_side            i_side,
    output logic                      o_valid,
    output logic [DIV_NUM_W-1:0]      o_quot,
    output t_div_side                 o_side
);

    // Stage k reads index k and writes its registers into index k+1
    logic                 s_valid [DIV_NUM_W+1];
    logic [DIV_DEN_W-1:0] s_rem   [DIV_NUM_W+1];
    logic [DIV_NUM_W-1:0] s_nq    [DIV_NUM_W+1];
    logic [DIV_DEN_W-1:0] s_den   [DIV_NUM_W+1];
    t_div_side            s_side  [DIV_NUM_W+1];

    logic                 r_valid [DIV_NUM_W];
    logic [DIV_DEN_W-1:0] r_rem   [DIV_NUM_W];
    logic [DIV_NUM_W-1:0] r_nq    [DIV_NUM_W];
    logic [DIV_DEN_W-1:0] r_den   [DIV_NUM_W];
    t_div_side            r_side  [DIV_NUM_W];

    // Feed the first stage
    assign s_valid[0] = i_valid;
    assign s_rem[0]   = '0;
    assign s_nq[0]    = i_num;
    assign s_den[0]   = i_den;
    assign s_side[0]  = i_side;

    for (genvar k = 0; k < DIV_NUM_W; k++) begin : g_step
        logic [DIV_DEN_W:0] w_trial;
        logic               w_ge;

        // Shift in the next dividend bit and try the subtraction
        assign w_trial = {s_rem[k], s_nq[k][DIV_NUM_W-1]};
        assign w_ge    = (w_trial >= {1'b0, s_den[k]});

        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_valid[k] <= 1'b0;
            end else if (i_en) begin
                r_valid[k] <= s_valid[k];
            end
        end

        always_ff @(posedge i_clk) begin
            if (i_en) begin
                r_rem[k]  <= w_ge ? DIV_DEN_W'(w_trial - {1'b0, s_den[k]})
                                  : w_trial[DIV_DEN_W-1:0];
                r_nq[k]   <= {s_nq[k][DIV_NUM_W-2:0], w_ge};
                r_den[k]  <= s_den[k];
                r_side[k] <= s_side[k];
            end
        end

        assign s_valid[k+1] = r_valid[k];
        assign s_rem[k+1]   = r_rem[k];
        assign s_nq[k+1]    = r_nq[k];
        assign s_den[k+1]   = r_den[k];
        assign s_side[k+1]  = r_side[k];
    end

    // The remainder of the last stage is not needed
    assign o_valid = s_valid[DIV_NUM_W];
    assign o_quot  = s_nq[DIV_NUM_W];
    assign o_side  = s_side[DIV_NUM_W];

endmodule

`default_nettype wire

### rtl/core/ptc_checker.sv
// Port-level checks of the compensation core and their binding to the top level.
`timescale 1ns / 1ps
`default_nettype none

module ptc_checker (
    input wire logic               i_clk,
    input wire logic               i_rst_n,
    input wire logic               i_out_valid,
    input wire logic               i_out_ready,
    input wire logic signed [14:0] i_temp,
    input wire logic [31:0]        i_press,
    input wire logic               i_inv
);

    // A stalled result beat stays offered
    a_valid_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && !i_out_ready |=> i_out_valid)
        else $error("result beat withdrawn under stall");

    // A stalled result beat keeps its payload
    a_payload_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && !i_out_ready |=> $stable(i_temp) && $stable(i_press) && $stable(i_inv))
        else $error("result payload changed under stall");

    // A zero denominator forces the pressure to zero
    a_invalid_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && i_inv |-> i_press == 32'd0)
        else $error("invalid pressure not zero");

    // Temperature stays within its saturation limits
    a_temp_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid |-> (i_temp >= -15'sd4000) && (i_temp <= 15'sd8500))
        else $error("temperature outside limits");

    // Reset drops every beat in flight
    a_reset_flush: assert property (@(posedge i_clk)
        !i_rst_n |=> !i_out_valid)
        else $error("result beat after reset");

endmodule

bind pressure_temperature_compensation_core ptc_checker u_ptc_checker (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .i_out_valid (o_out.valid),
    .i_out_ready (o_out.ready),
    .i_temp      (o_out.temperature_centi),
    .i_press     (o_out.pressure_q24_8),
    .i_inv       (o_out.pressure_invalid)
);

`default_nettype wire
